[hw/rtl/i2cbm_pkg.sv]
// Shared types and constants for the I2C bit-level master.
// Holds operation codes, the controller state record and the result record.
// No dependencies.
package i2cbm_pkg;

	localparam int unsigned OpW        = 4;
	localparam int unsigned ByteW      = 8;
	localparam int unsigned AddrW      = 7;
	localparam int unsigned TicksW     = 16;
	localparam int unsigned PhaseW     = 2;
	localparam int unsigned BitCntW    = 4;
	localparam int unsigned InTdataW   = 24;
	localparam int unsigned OutTdataW  = 16;

	localparam logic [TicksW-1:0] PhaseTicksReset = 16'h0001;
	localparam logic [BitCntW-1:0] ByteBits       = 4'd8;

	localparam logic [OpW-1:0] OP_TICK    = 4'd0;
	localparam logic [OpW-1:0] OP_IDLE    = 4'd1;
	localparam logic [OpW-1:0] OP_START   = 4'd2;
	localparam logic [OpW-1:0] OP_STOP    = 4'd3;
	localparam logic [OpW-1:0] OP_ACK     = 4'd4;
	localparam logic [OpW-1:0] OP_NACK    = 4'd5;
	localparam logic [OpW-1:0] OP_WAITACK = 4'd6;
	localparam logic [OpW-1:0] OP_WRITE   = 4'd7;
	localparam logic [OpW-1:0] OP_READ    = 4'd8;
	localparam logic [OpW-1:0] OP_ADDRESS = 4'd9;

	localparam logic [PhaseW-1:0] PH_SCL_LOW  = 2'd0;
	localparam logic [PhaseW-1:0] PH_SDA_SET  = 2'd1;
	localparam logic [PhaseW-1:0] PH_SCL_HIGH = 2'd2;
	localparam logic [PhaseW-1:0] PH_SDA_END  = 2'd3;

	typedef struct packed {
		logic [OpW-1:0]     cmd;
		logic [PhaseW-1:0]  phase;
		logic [BitCntW-1:0] bit_cnt;
		logic [ByteW-1:0]   shift;
		logic [TicksW-1:0]  ticks;
		logic               scl;
		logic               sda;
		logic               drive;
		logic [ByteW-1:0]   read_byte;
		logic               ack;
	} ctrl_state_t;

	localparam ctrl_state_t StateReset = '{
		cmd: OP_TICK, phase: PH_SCL_LOW, bit_cnt: '0, shift: '0, ticks: '0,
		scl: 1'b1, sda: 1'b1, drive: 1'b1, read_byte: '0, ack: 1'b0
	};

	typedef struct packed {
		logic             rejected;
		logic             busy_res;
		logic             done_res;
		logic             ack_received;
		logic [ByteW-1:0] read_data;
		logic             sda_drive;
		logic             sda_out;
		logic             scl;
	} result_t;

endpackage

[hw/rtl/i2cbm_core.sv]
// Next-state and result logic of the I2C bit-level master for one request.
// Depends on i2cbm_pkg.
module i2cbm_core import i2cbm_pkg::*; (
	input  ctrl_state_t        cur,
	input  logic [TicksW-1:0]  phase_ticks,
	input  logic [OpW-1:0]     operation,
	input  logic [ByteW-1:0]   write_data,
	input  logic [AddrW-1:0]   address,
	input  logic               read_not_write,
	input  logic               sda_in,
	output ctrl_state_t        nxt,
	output result_t            res
);

	logic [TicksW-1:0]  len;
	logic               is_cmd;
	logic               do_enter;
	logic               done;
	logic               rej;
	logic [PhaseW-1:0]  last_phase;
	logic [BitCntW-1:0] bit_cnt_inc;
	logic [ByteW-1:0]   shifted;

	always_comb begin
		len         = (phase_ticks == '0) ? {{(TicksW-1){1'b0}}, 1'b1} : phase_ticks;
		is_cmd      = (operation >= OP_IDLE) && (operation <= OP_ADDRESS);
		last_phase  = ((cur.cmd == OP_START) || (cur.cmd == OP_STOP)) ? PH_SDA_END : PH_SCL_HIGH;
		bit_cnt_inc = cur.bit_cnt + 1'b1;
		shifted     = (cur.cmd == OP_READ) ? {cur.shift[ByteW-2:0], sda_in}
		                                   : {cur.shift[ByteW-2:0], 1'b0};
		nxt         = cur;
		do_enter    = 1'b0;
		done        = 1'b0;
		rej         = 1'b0;

		if (cur.cmd != OP_TICK) begin
			rej = is_cmd;
			if (cur.ticks >= len) begin
				if (cur.phase < last_phase) begin
					nxt.phase = cur.phase + 1'b1;
					do_enter  = 1'b1;
				end else begin
					done = 1'b1;
					if (cur.cmd == OP_WAITACK) begin
						nxt.ack = ~sda_in;
					end else if ((cur.cmd == OP_READ) || (cur.cmd == OP_WRITE) ||
					             (cur.cmd == OP_ADDRESS)) begin
						nxt.shift   = shifted;
						nxt.bit_cnt = bit_cnt_inc;
						if (bit_cnt_inc < ByteBits) begin
							// More bits to go: restart the bit with SCL low.
							nxt.phase = PH_SCL_LOW;
							do_enter  = 1'b1;
							done      = 1'b0;
						end else if (cur.cmd == OP_READ) begin
							nxt.read_byte = shifted;
						end
					end
					if (done) begin
						nxt.cmd     = OP_TICK;
						nxt.phase   = PH_SCL_LOW;
						nxt.bit_cnt = '0;
						nxt.ticks   = '0;
					end
				end
			end else begin
				nxt.ticks = cur.ticks + 1'b1;
			end
		end else if (is_cmd) begin
			nxt.cmd     = operation;
			nxt.phase   = PH_SCL_LOW;
			nxt.bit_cnt = '0;
			do_enter    = 1'b1;
			case (operation)
				OP_WRITE:   nxt.shift = write_data;
				OP_ADDRESS: nxt.shift = {address, read_not_write};
				OP_READ:    nxt.shift = '0;
				default:    nxt.shift = cur.shift;
			endcase
		end

		// Line levels set on entry to a phase.
		if (do_enter) begin
			nxt.ticks = {{(TicksW-1){1'b0}}, 1'b1};
			case (nxt.phase)
				PH_SCL_LOW: begin
					nxt.scl = 1'b0;
					if ((nxt.cmd == OP_WAITACK) || (nxt.cmd == OP_READ)) begin
						nxt.drive = 1'b0;
						nxt.sda   = 1'b1;
					end else begin
						nxt.drive = 1'b1;
					end
				end
				PH_SDA_SET: begin
					if ((nxt.cmd == OP_IDLE) || (nxt.cmd == OP_START) || (nxt.cmd == OP_NACK))
						nxt.sda = 1'b1;
					else if ((nxt.cmd == OP_STOP) || (nxt.cmd == OP_ACK))
						nxt.sda = 1'b0;
					else if ((nxt.cmd == OP_WRITE) || (nxt.cmd == OP_ADDRESS))
						nxt.sda = nxt.shift[ByteW-1];
				end
				PH_SCL_HIGH: begin
					nxt.scl = 1'b1;
				end
				default: begin
					if (nxt.cmd == OP_START)
						nxt.sda = 1'b0;
					else if (nxt.cmd == OP_STOP)
						nxt.sda = 1'b1;
				end
			endcase
		end

		res.scl          = nxt.scl;
		res.sda_out      = nxt.sda;
		res.sda_drive    = nxt.drive;
		res.read_data    = nxt.read_byte;
		res.ack_received = nxt.ack;
		res.done_res     = done;
		res.busy_res     = (nxt.cmd != OP_TICK);
		res.rejected     = rej;
	end

endmodule

[hw/rtl/i2c_bit_level_master_top.sv]
// Top level of the I2C bit-level master: controller state, phase length register,
// output register and stream handshakes. Depends on i2cbm_pkg and i2cbm_core.
//
//   channel   | ports                                 | content
//   ----------+---------------------------------------+-------------------------------
//   input     | s_tvalid, s_tready, s_tdata[23:0]     | one command or tick request
//   output    | m_tvalid, m_tready, m_tdata[15:0]     | line levels and status result
//   config    | cfg_we, cfg_wdata[15:0]               | phase_ticks register
//
// Every accepted request produces exactly one result in the next cycle, and a new
// request can be accepted in every cycle while the output is not stalled. The state
// update for a request is one pass of combinational logic from the state registers
// into the state registers, and the result lands in a single output register.
// The input is ready whenever the output register is empty or is being emptied in
// the same cycle, so a stall on the output side costs no more than the held result.
// The asynchronous reset puts the lines to idle high with SDA driven, clears any
// running command and sets the phase length to one tick.
module i2c_bit_level_master_top import i2cbm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [3:0] operation, [11:4] write_data, [18:12] address, [19] read_not_write,
	// [20] sda_in, [23:21] zero
	input  logic [InTdataW-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] scl, [1] sda_out, [2] sda_drive, [10:3] read_data, [11] ack_received,
	// [12] done_res, [13] busy_res, [14] rejected, [15] zero
	output logic [OutTdataW-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [TicksW-1:0]    cfg_wdata
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_nxt;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;
	logic [TicksW-1:0] phase_ticks_q;
	logic              accept;

	// The input side waits only when a result is held and not taken.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	i2cbm_core u_core (
		.cur            (state_q),
		.phase_ticks    (phase_ticks_q),
		.operation      (s_tdata[3:0]),
		.write_data     (s_tdata[11:4]),
		.address        (s_tdata[18:12]),
		.read_not_write (s_tdata[19]),
		.sda_in         (s_tdata[20]),
		.nxt            (state_nxt),
		.res            (res)
	);

	// Phase length register; a value of zero is treated as one by the core.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PhaseTicksReset;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Controller state advances only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

endmodule

[hw/rtl/i2cbm_checker.sv]
// Port-level checker for the I2C bit-level master, bound to the top level.
// Depends on i2cbm_pkg for widths.
module i2cbm_checker import i2cbm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OutTdataW-1:0] m_tdata
);

	// A held result stays put until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output result changed while stalled");

	// A rejected request can only come while a command is running, which then
	// either goes on or ends on that request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[13] || m_tdata[12])
		else $error("rejection without a running command");

	// A finished command is never reported as still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
		else $error("done and busy in one result");

	// A released data line always reads back high.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[1])
		else $error("released SDA not shown high");

endmodule

bind i2c_bit_level_master_top i2cbm_checker u_i2cbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
